FILE: rtl/svd_pkg.sv
// Shared types and constants for the bit-stuffed varint decoder.
// No dependencies; used by every module of the block.
package svd_pkg;

   // Fixed widths of the result fields and the run counter
   localparam int VAL_W = 64;
   localparam int CNT_W = 7;
   localparam int RUN_W = 4;

   // Run limit after reset, and the smallest run limit that takes effect
   localparam logic [RUN_W-1:0] RUN_LIMIT_RESET = 4'd3;
   localparam logic [RUN_W-1:0] RUN_LIMIT_MIN = 4'd2;

   // One decoded number
   typedef struct packed {
      logic overflow;
      logic [CNT_W-1:0] data_bits;
      logic [VAL_W-1:0] value;
   } result_type;

endpackage

FILE: rtl/svd_core.sv
// Input register and decode state for the bit-stuffed varint decoder.
// Depends on svd_pkg; feeds one result item at a time to svd_out.
module svd_core #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic code_bit,
   input  logic [svd_pkg::RUN_W-1:0] run_limit,
   input  logic slot_open,
   output logic res_valid,
   output svd_pkg::result_type res
);
   import svd_pkg::*;

   localparam int IDX_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

   // Input register
   logic in_valid_ff, in_valid_in;
   logic in_bit_ff;

   // Decode state
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] bit_count_ff, bit_count_in;
   logic [RUN_W-1:0] run_count_ff, run_count_in;
   logic last_bit_ff, last_bit_in;
   logic expect_stuff_ff, expect_stuff_in;
   logic overflow_ff, overflow_in;

   logic emit;
   logic fire;
   logic [RUN_W-1:0] limit;
   logic [RUN_W-1:0] run_next;
   logic [VAL_W-1:0] fill;

   // Terminator: a control bit equal to the current run
   assign emit = expect_stuff_ff && (in_bit_ff == last_bit_ff);
   // Advance the held item unless its result has nowhere to go
   assign fire = in_valid_ff && (!emit || slot_open);
   assign req_tready = !in_valid_ff || fire;
   assign res_valid = fire && emit;

   assign limit = (run_limit < RUN_LIMIT_MIN) ? RUN_LIMIT_MIN : run_limit;
   assign run_next = run_count_ff + 1'b1;

   // Build the result: fill bits above the data with the terminator polarity
   assign fill = last_bit_ff ? ({VAL_W{1'b1}} << bit_count_ff) : '0;
   assign res.value = VAL_W'(acc_ff) | fill;
   assign res.data_bits = bit_count_ff;
   assign res.overflow = overflow_ff;

   always_comb begin
      in_valid_in = (in_valid_ff && !fire) || (req_tvalid && req_tready);
      acc_in = acc_ff;
      bit_count_in = bit_count_ff;
      run_count_in = run_count_ff;
      last_bit_in = last_bit_ff;
      expect_stuff_in = expect_stuff_ff;
      overflow_in = overflow_ff;
      if (fire) begin
         if (expect_stuff_ff) begin
            if (emit) begin
               // clear all decoding state after the terminator
               acc_in = '0;
               bit_count_in = '0;
               run_count_in = '0;
               last_bit_in = 1'b0;
               expect_stuff_in = 1'b0;
               overflow_in = 1'b0;
            end else begin
               // drop the stuffed bit and start a new run
               last_bit_in = in_bit_ff;
               run_count_in = RUN_W'(1);
               expect_stuff_in = 1'b0;
            end
         end else begin
            // keep the data bit, or drop it once the value is full
            if (bit_count_ff < CNT_W'(VALUE_WIDTH)) begin
               acc_in[bit_count_ff[IDX_W-1:0]] = acc_ff[bit_count_ff[IDX_W-1:0]] | in_bit_ff;
               bit_count_in = bit_count_ff + 1'b1;
            end else begin
               overflow_in = 1'b1;
            end
            // track the run of equal bits
            if (in_bit_ff != last_bit_ff) begin
               last_bit_in = in_bit_ff;
               run_count_in = RUN_W'(1);
            end else begin
               run_count_in = run_next;
               if (run_next == limit) begin
                  expect_stuff_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         acc_ff <= '0;
         bit_count_ff <= '0;
         run_count_ff <= '0;
         last_bit_ff <= 1'b0;
         expect_stuff_ff <= 1'b0;
         overflow_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         acc_ff <= acc_in;
         bit_count_ff <= bit_count_in;
         run_count_ff <= run_count_in;
         last_bit_ff <= last_bit_in;
         expect_stuff_ff <= expect_stuff_in;
         overflow_ff <= overflow_in;
      end
   end

   // Capture the incoming bit when the item is accepted
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_bit_ff <= code_bit;
      end
   end

endmodule

FILE: rtl/svd_out.sv
// Result register of the bit-stuffed varint decoder.
// Depends on svd_pkg; holds one decoded item until the sink takes it.
module svd_out (
   input  logic clock,
   input  logic reset,
   input  logic res_valid,
   input  svd_pkg::result_type res,
   output logic slot_open,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output svd_pkg::result_type rsp_res
);
   import svd_pkg::*;

   logic out_valid_ff, out_valid_in;
   result_type out_data_ff;

   // Slot is free when empty or being emptied this cycle
   assign slot_open = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_res = out_data_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (res_valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Load a new result item
   always_ff @(posedge clock) begin
      if (res_valid) begin
         out_data_ff <= res;
      end
   end

endmodule

FILE: rtl/stuffed_varint_decoder.sv
// Bit-stuffed signed varint decoder, top level.
// Depends on svd_pkg, svd_core and svd_out.
//
// Takes one code bit per item, least significant first. After run_limit equal
// bits the next bit is a control bit: an opposite bit is stuffed and dropped,
// an equal bit terminates the number and produces one result item holding the
// value (upper bits filled with the terminator polarity), the count of data
// bits and a sticky overflow flag. One item is taken every clock unless the
// input stalls; each item passes an input register and, if it terminates a
// number, a result register, so a result item is offered once its terminator
// bit has left the input register. The input stalls only when a terminator
// meets a full result register that is not being read in the same cycle.
// Write run_limit only while no item is in flight; values 0 and 1 act as 2.
module stuffed_varint_decoder #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,   // [0] code_bit, [7:1] zero
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [71:0] rsp_tdata,  // [63:0] value, [70:64] data_bits, [71] overflow
   input  logic csr_wr_en,
   input  logic [3:0] csr_wr_data  // run_limit
);
   import svd_pkg::*;

   logic [RUN_W-1:0] run_limit_ff;
   logic slot_open;
   logic res_valid;
   result_type res;
   result_type rsp_res;

   // Hold the run limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         run_limit_ff <= RUN_LIMIT_RESET;
      end else if (csr_wr_en) begin
         run_limit_ff <= csr_wr_data;
      end
   end

   svd_core #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .code_bit(req_tdata[0]),
      .run_limit(run_limit_ff),
      .slot_open(slot_open),
      .res_valid(res_valid),
      .res(res)
   );

   svd_out u_out (
      .clock(clock),
      .reset(reset),
      .res_valid(res_valid),
      .res(res),
      .slot_open(slot_open),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_res(rsp_res)
   );

   // Pack the result fields, value in the lowest bits
   assign rsp_tdata = {rsp_res.overflow, rsp_res.data_bits, rsp_res.value};

endmodule

FILE: test/stuffed_varint_decoder_tb.sv
// Self-checking testbench for stuffed_varint_decoder: streams bit-stuffed code bits,
// predicts each decoded number in-line and compares every result item field by field.
// Depends on svd_pkg and the stuffed_varint_decoder RTL.
module stuffed_varint_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import svd_pkg::*;

   localparam int ITEMS = 1000;          // rough number of code bits to send
   localparam int PHASE_BITS = 120;      // code bits per run-limit setting
   localparam int SETTLE_CYCLES = 4;     // pipeline depth plus margin before a register write
   localparam int HOLD_CYCLES = 300;     // long receiver hold-off
   localparam int DRAIN_CYCLES = 12;     // quiet time at the end

   typedef enum logic {ENT_BIT, ENT_LIMIT} entry_kind_type;

   typedef struct {
      entry_kind_type kind;
      logic code_bit;
      logic [RUN_W-1:0] limit;
   } code_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'd0;     // [0] code_bit, [7:1] zero
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;           // [63:0] value, [70:64] data_bits, [71] overflow
   logic csr_wr_en = 1'b0;
   logic [3:0] csr_wr_data = 4'd0;   // run_limit

   // Pending stimulus and decoded numbers still owed by the block
   code_entry_type code_fifo[$];
   result_type decoded_fifo[$];

   int bits_offered = 0;
   int bits_taken = 0;
   int fail_count = 0;
   int stress_from = -1;

   // Decoder shadow state, updated on every accepted item
   logic [RUN_W-1:0] run_limit_q = RUN_LIMIT_RESET;
   logic [VAL_W-1:0] acc_bits = '0;
   logic [CNT_W-1:0] kept_bits = '0;
   logic [RUN_W-1:0] run_len = '0;
   logic run_bit = 1'b0;
   logic stuff_due = 1'b0;
   logic dropped = 1'b0;

   // Encoder run tracking, used only while building the stimulus
   logic [RUN_W-1:0] enc_limit = RUN_LIMIT_RESET;
   logic [RUN_W-1:0] enc_len = '0;
   logic enc_bit = 1'b0;
   logic enc_due = 1'b0;
   int gen_bits = 0;

   stuffed_varint_decoder DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   // Feed one code bit into the decoder shadow; queue a number on its terminator
   function automatic void decode_bit(input logic b);
      result_type r;
      logic [RUN_W-1:0] lim;
      lim = (run_limit_q < RUN_LIMIT_MIN) ? RUN_LIMIT_MIN : run_limit_q;
      if (stuff_due) begin
         if (b == run_bit) begin
            r.value = acc_bits;
            if (run_bit && kept_bits < VAL_W)
               r.value = r.value | ({VAL_W{1'b1}} << kept_bits);
            r.data_bits = kept_bits;
            r.overflow = dropped;
            decoded_fifo.push_back(r);
            acc_bits = '0;
            kept_bits = '0;
            run_len = '0;
            run_bit = 1'b0;
            dropped = 1'b0;
         end else begin
            // stuffed bit: drop it and restart the run
            run_bit = b;
            run_len = RUN_W'(1);
         end
         stuff_due = 1'b0;
         return;
      end
      if (kept_bits < VAL_W) begin
         acc_bits[kept_bits[5:0]] = b;
         kept_bits = kept_bits + 1'b1;
      end else begin
         dropped = 1'b1;
      end
      if (b != run_bit) begin
         run_bit = b;
         run_len = RUN_W'(1);
      end else begin
         run_len = run_len + 1'b1;
         if (run_len == lim)
            stuff_due = 1'b1;
      end
   endfunction

   // Queue one raw code bit and track the run the decoder will see
   function automatic void send_code_bit(input logic b);
      code_entry_type e;
      logic [RUN_W-1:0] lim;
      e.kind = ENT_BIT;
      e.code_bit = b;
      e.limit = '0;
      code_fifo.push_back(e);
      gen_bits++;
      lim = (enc_limit < RUN_LIMIT_MIN) ? RUN_LIMIT_MIN : enc_limit;
      if (enc_due) begin
         if (b == enc_bit) begin
            enc_bit = 1'b0;
            enc_len = '0;
         end else begin
            enc_bit = b;
            enc_len = RUN_W'(1);
         end
         enc_due = 1'b0;
      end else if (b != enc_bit) begin
         enc_bit = b;
         enc_len = RUN_W'(1);
      end else begin
         enc_len = enc_len + 1'b1;
         if (enc_len == lim)
            enc_due = 1'b1;
      end
   endfunction

   // Encode a number: data bits with stuffing, then pad to a full run and terminate
   function automatic void send_number(input int nbits, input logic [79:0] data,
                                       input logic fill);
      for (int i = 0; i < nbits; i++) begin
         if (enc_due)
            send_code_bit(~enc_bit);
         send_code_bit(data[i]);
      end
      while (!(enc_due && enc_bit == fill)) begin
         if (enc_due)
            send_code_bit(~enc_bit);
         else
            send_code_bit(fill);
      end
      send_code_bit(fill);
   endfunction

   // Queue a run-limit write; the driver holds it until the block is idle
   function automatic void send_run_limit(input logic [RUN_W-1:0] v);
      code_entry_type e;
      e.kind = ENT_LIMIT;
      e.code_bit = 1'b0;
      e.limit = v;
      code_fifo.push_back(e);
      enc_limit = v;
   endfunction

   // Mostly no gap, some short ones, a few long ones
   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Sample both channels and the register port at the rising edge
   always @(posedge clock) begin : observe
      result_type got;
      result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata);
            if (decoded_fifo.size() == 0) begin
               $display("%0t: unexpected result item: expected none, got %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = decoded_fifo.pop_front();
               if (got.value !== want.value) begin
                  $display("%0t: value mismatch: expected %h, got %h",
                           $time, want.value, got.value);
                  fail_count++;
               end
               if (got.data_bits !== want.data_bits) begin
                  $display("%0t: data_bits mismatch: expected %0d, got %0d",
                           $time, want.data_bits, got.data_bits);
                  fail_count++;
               end
               if (got.overflow !== want.overflow) begin
                  $display("%0t: overflow mismatch: expected %b, got %b",
                           $time, want.overflow, got.overflow);
                  fail_count++;
               end
            end
         end
         if (csr_wr_en)
            run_limit_q = csr_wr_data;
         if (req_tvalid && req_tready) begin
            decode_bit(req_tdata[0]);
            bits_taken++;
         end
      end
   end

   // Drive code bits and register writes at the falling edge
   always @(negedge clock) begin : drive
      logic nxt_valid;
      logic nxt_bit;
      logic nxt_wr;
      logic [3:0] nxt_data;
      int send_gap;
      int quiet;
      int mode_left;
      bit calm;
      nxt_valid = req_tvalid;
      nxt_bit = req_tdata[0];
      nxt_wr = 1'b0;
      nxt_data = csr_wr_data;
      // hold the item until it is taken
      if (!reset && !(req_tvalid && bits_taken != bits_offered)) begin
         nxt_valid = 1'b0;
         if (mode_left == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(50, 200);
         end else begin
            mode_left--;
         end
         if (send_gap > 0) begin
            send_gap--;
         end else if (code_fifo.size() > 0) begin
            if (code_fifo[0].kind == ENT_BIT) begin
               nxt_valid = 1'b1;
               nxt_bit = code_fifo[0].code_bit;
               void'(code_fifo.pop_front());
               bits_offered++;
               send_gap = pick_gap(calm);
            end else if (decoded_fifo.size() != 0) begin
               quiet = 0;
            end else if (quiet < SETTLE_CYCLES) begin
               quiet++;
            end else begin
               // block is drained and settled: write the register
               nxt_wr = 1'b1;
               nxt_data = code_fifo[0].limit;
               void'(code_fifo.pop_front());
               quiet = 0;
            end
         end
      end
      req_tvalid <= nxt_valid;
      req_tdata <= {7'd0, nxt_bit};
      csr_wr_en <= nxt_wr;
      csr_wr_data <= nxt_data;
   end

   // Result side backpressure, with one long hold-off during the stress phase
   always @(negedge clock) begin : accept
      int hold_left;
      int recv_gap;
      int mode_left;
      bit calm;
      bit hold_done;
      if (!reset) begin
         if (!hold_done && stress_from >= 0 && bits_taken >= stress_from + 20) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(50, 200);
         end else begin
            mode_left--;
         end
         if (hold_left > 0)
            hold_left--;
         else if (recv_gap > 0)
            recv_gap--;
         else
            recv_gap = pick_gap(calm);
         rsp_tready <= (hold_left == 0 && recv_gap == 0);
      end
   end

   // Build the stimulus, release reset, wait for the block to drain
   initial begin : stimulus
      logic [RUN_W-1:0] plan[4];
      logic [RUN_W-1:0] lim;
      int phase;
      int phase_end;
      int r;
      int nbits;
      plan = '{4'd15, 4'd2, 4'd0, 4'd1};

      // directed part at the reset run limit
      send_number(0, '0, 1'b0);                  // shortest zero: only the terminating run
      send_number(0, '0, 1'b1);                  // shortest negative: all ones
      send_number(12, 80'h0F0, 1'b0);            // long runs force stuffed bits
      send_number(8, 80'h55, 1'b1);              // alternating, no stuffing
      send_number(64, 80'({$urandom, $urandom, $urandom}), 1'b1);  // full value, no fill
      send_number(70, 80'({$urandom, $urandom, $urandom}), 1'b0);  // bits past 64 dropped

      // random phases, each with its own run limit
      phase = 0;
      while (gen_bits < ITEMS) begin
         lim = (phase < 4) ? plan[phase] : 4'($urandom_range(0, 15));
         send_run_limit(lim);
         if (phase == 1)
            stress_from = gen_bits;
         phase_end = gen_bits + PHASE_BITS;
         while (gen_bits < phase_end) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               // noise: raw bits, may break the number in progress
               repeat ($urandom_range(1, 12))
                  send_code_bit(1'($urandom_range(0, 1)));
            end else begin
               r = $urandom_range(0, 99);
               if (r < 80)
                  nbits = $urandom_range(0, 16);
               else if (r < 95)
                  nbits = $urandom_range(17, 64);
               else
                  nbits = $urandom_range(65, 80);
               send_number(nbits, 80'({$urandom, $urandom, $urandom}),
                           1'($urandom_range(0, 1)));
            end
         end
         phase++;
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (code_fifo.size() != 0 || bits_taken != bits_offered || decoded_fifo.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (decoded_fifo.size() != 0) begin
         $display("%0t: expected %h, got nothing (%0d results missing)",
                  $time, decoded_fifo[0], decoded_fifo.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
